// File: src/ffa_pkg.sv
`default_nettype none

package ffa_pkg;

  localparam int unsigned CFG_W      = 13;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned REPLY_W    = 13;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned HDR_BYTES  = 12;
  localparam int unsigned MAX_BLOCKS = 511;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

endpackage

`default_nettype wire

// File: src/ffa_ram.sv
`default_nettype none

module ffa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: src/first_fit_arena_allocator_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  func_i, request_size_i, position_i
// out      output     out_valid_o/out_stall_i reply_o
// cfg      input      cfg_we_i               cfg_wdata_i (arena_bytes_used)
//
// one request at a time through a single-port byte ram, one byte access a cycle.
// a header word is four byte reads or four byte writes; an allocate visits each
// block with two word reads and a compare, plus up to five header word writes.
// a free walks the same way, then zeroes size+12 bytes at one byte a cycle, stopping
// at the arena end. a byte read addresses the ram in S_RB and takes the data in S_RB2.
// after reset a clearing pass zeroes every arena byte before the first request is taken.
// a stalled result sits in the output register while the next request runs.
`default_nettype none

module first_fit_arena_allocator_unit import ffa_pkg::*; #(
  parameter int unsigned ARENA_BYTES = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [FUNC_W-1:0]  func_i,
  input  wire logic [SIZE_W-1:0]  request_size_i,
  input  wire logic [POS_W-1:0]   position_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [REPLY_W-1:0] reply_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(ARENA_BYTES);
  localparam int unsigned VW   = (AW + 1 > 14) ? AW + 1 : 14;
  localparam int unsigned WQ_N = 5;
  localparam logic [VW-1:0] ARENA_V = VW'(ARENA_BYTES);
  localparam logic [VW-1:0] HDR_V   = VW'(HDR_BYTES);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A0    = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_AEVAL = 4'd4;
  localparam logic [3:0] S_FEVAL = 4'd5;
  localparam logic [3:0] S_WQ    = 4'd6;
  localparam logic [3:0] S_RB    = 4'd7;
  localparam logic [3:0] S_RB2   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [3:0]         ret_q, ret_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [VW-1:0]      first_q, first_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [REPLY_W-1:0] reply_q, reply_d;

  logic [FUNC_W-1:0]  func_q, func_d;
  logic [VW-1:0]      need_q, need_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [VW-1:0]      pos_q, pos_d;
  logic [VW-1:0]      cur_q, cur_d;
  logic [VW-1:0]      prv_q, prv_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [VW-1:0]      sz_q, sz_d;
  logic [VW-1:0]      nxt_q, nxt_d;
  logic [REPLY_W-1:0] res_q, res_d;
  logic [VW-1:0]      rd_base_q, rd_base_d;
  logic               rd_sel_q, rd_sel_d;
  logic [2:0]         rk_q, rk_d;
  logic [31:0]        rword_q, rword_d;
  logic [VW-1:0]      clr_q, clr_d;
  logic [VW-1:0]      clr_end_q, clr_end_d;
  logic [VW-1:0]      wq_addr_q [WQ_N];
  logic [VW-1:0]      wq_addr_d [WQ_N];
  logic [31:0]        wq_data_q [WQ_N];
  logic [31:0]        wq_data_d [WQ_N];
  logic [2:0]         wq_n_q, wq_n_d;
  logic [2:0]         wq_idx_q, wq_idx_d;
  logic [1:0]         wb_q, wb_d;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [7:0]         mem_wdata;
  logic [7:0]         mem_rdata;

  logic [VW-1:0]      lim;
  logic [VW-1:0]      blk_end;
  logic               is_last;
  logic [31:0]        word_now;
  logic [VW-1:0]      wq_byte_addr;
  logic [VW-1:0]      clr_lim;

  ffa_ram #(
    .Width (8),
    .Depth (ARENA_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign lim          = (VW'(cfg_q) > ARENA_V) ? ARENA_V : VW'(cfg_q);
  assign blk_end      = cur_q + HDR_V + sz_q;
  assign is_last      = (idx_q + CNT_W'(1) == cnt_q) || (nxt_q == '0);
  assign word_now     = {mem_rdata, rword_q[31:8]};
  assign wq_byte_addr = wq_addr_q[wq_idx_q] + VW'(wb_q);
  assign clr_lim      = (cur_q + sz_q + HDR_V > ARENA_V) ? ARENA_V
                                                         : cur_q + sz_q + HDR_V;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign reply_o     = reply_q;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    first_d     = first_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & out_stall_i;
    reply_d     = reply_q;
    func_d      = func_q;
    need_d      = need_q;
    size_d      = size_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    prv_d       = prv_q;
    idx_d       = idx_q;
    sz_d        = sz_q;
    nxt_d       = nxt_q;
    res_d       = res_q;
    rd_base_d   = rd_base_q;
    rd_sel_d    = rd_sel_q;
    rk_d        = rk_q;
    rword_d     = rword_q;
    clr_d       = clr_q;
    clr_end_d   = clr_end_q;
    wq_addr_d   = wq_addr_q;
    wq_data_d   = wq_data_q;
    wq_n_d      = wq_n_q;
    wq_idx_d    = wq_idx_q;
    wb_d        = wb_q;
    mem_we      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = '0;

    case (state_q)
      S_CLR: begin
        if (clr_q >= clr_end_q) begin
          state_d = ret_q;
        end else begin
          mem_we   = 1'b1;
          mem_addr = clr_q[AW-1:0];
          clr_d    = clr_q + VW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          size_d = request_size_i;
          need_d = VW'(request_size_i) + HDR_V;
          pos_d  = VW'(position_i);
          case (func_i)
            FUNC_ALLOC: state_d = S_A0;
            FUNC_FREE: begin
              if (cnt_q == '0) begin
                res_d   = '0;
                state_d = S_FIN;
              end else begin
                cur_d     = first_q;
                prv_d     = '0;
                idx_d     = '0;
                rd_base_d = first_q + VW'(8);
                rd_sel_d  = 1'b0;
                rk_d      = '0;
                state_d   = S_RD;
              end
            end
            FUNC_READ: state_d = S_RB;
            default: begin
              res_d   = '0;
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_A0: begin
        wq_idx_d = '0;
        wb_d     = '0;
        ret_d    = S_FIN;
        if (cnt_q >= CNT_W'(MAX_BLOCKS)) begin
          res_d   = '0;
          state_d = S_FIN;
        end else if (cnt_q == '0) begin
          if (lim < need_q) begin
            res_d   = '0;
            state_d = S_FIN;
          end else begin
            wq_addr_d[0] = VW'(0); wq_data_d[0] = '0;
            wq_addr_d[1] = VW'(4); wq_data_d[1] = '0;
            wq_addr_d[2] = VW'(8); wq_data_d[2] = 32'(size_q);
            wq_n_d  = 3'd3;
            first_d = '0;
            cnt_d   = CNT_W'(1);
            res_d   = REPLY_W'(HDR_BYTES);
            state_d = S_WQ;
          end
        end else if (first_q >= need_q) begin
          wq_addr_d[0] = VW'(0); wq_data_d[0] = 32'(first_q);
          wq_addr_d[1] = VW'(4); wq_data_d[1] = '0;
          wq_addr_d[2] = VW'(8); wq_data_d[2] = 32'(size_q);
          wq_addr_d[3] = first_q + VW'(4); wq_data_d[3] = '0;
          wq_n_d  = 3'd4;
          first_d = '0;
          cnt_d   = cnt_q + CNT_W'(1);
          res_d   = REPLY_W'(HDR_BYTES);
          state_d = S_WQ;
        end else begin
          cur_d     = first_q;
          idx_d     = '0;
          rd_base_d = first_q + VW'(8);
          rd_sel_d  = 1'b0;
          rk_d      = '0;
          state_d   = S_RD;
        end
      end

      // word read: four byte reads, data arrives the cycle after its address
      S_RD: begin
        if (rk_q != 3'd4) begin
          mem_addr = AW'(rd_base_q + VW'(rk_q));
        end
        if (rk_q != 3'd0) begin
          rword_d = word_now;
        end
        rk_d = rk_q + 3'd1;
        if (rk_q == 3'd4) begin
          rk_d = '0;
          if (!rd_sel_q) begin
            sz_d      = word_now[VW-1:0];
            rd_sel_d  = 1'b1;
            rd_base_d = cur_q;
          end else begin
            nxt_d   = word_now[VW-1:0];
            state_d = (func_q == FUNC_ALLOC) ? S_AEVAL : S_FEVAL;
          end
        end
      end

      S_AEVAL: begin
        wq_idx_d = '0;
        wb_d     = '0;
        ret_d    = S_FIN;
        if (is_last) begin
          if (blk_end > lim || lim - blk_end < need_q) begin
            res_d   = '0;
            state_d = S_FIN;
          end else begin
            wq_addr_d[0] = cur_q;              wq_data_d[0] = 32'(blk_end);
            wq_addr_d[1] = blk_end;            wq_data_d[1] = '0;
            wq_addr_d[2] = blk_end + VW'(4);   wq_data_d[2] = 32'(cur_q);
            wq_addr_d[3] = blk_end + VW'(8);   wq_data_d[3] = 32'(size_q);
            wq_n_d  = 3'd4;
            cnt_d   = cnt_q + CNT_W'(1);
            res_d   = REPLY_W'(blk_end + HDR_V);
            state_d = S_WQ;
          end
        end else if (nxt_q >= blk_end && nxt_q - blk_end >= need_q) begin
          wq_addr_d[0] = cur_q;              wq_data_d[0] = 32'(blk_end);
          wq_addr_d[1] = blk_end;            wq_data_d[1] = 32'(nxt_q);
          wq_addr_d[2] = blk_end + VW'(4);   wq_data_d[2] = 32'(cur_q);
          wq_addr_d[3] = blk_end + VW'(8);   wq_data_d[3] = 32'(size_q);
          wq_addr_d[4] = nxt_q + VW'(4);     wq_data_d[4] = 32'(blk_end);
          wq_n_d  = 3'd5;
          cnt_d   = cnt_q + CNT_W'(1);
          res_d   = REPLY_W'(blk_end + HDR_V);
          state_d = S_WQ;
        end else begin
          cur_d     = nxt_q;
          idx_d     = idx_q + CNT_W'(1);
          rd_base_d = nxt_q + VW'(8);
          rd_sel_d  = 1'b0;
          state_d   = S_RD;
        end
      end

      S_FEVAL: begin
        wq_idx_d = '0;
        wb_d     = '0;
        if (cur_q + HDR_V == pos_q) begin
          clr_d     = cur_q;
          clr_end_d = clr_lim;
          ret_d     = S_FIN;
          cnt_d     = cnt_q - CNT_W'(1);
          res_d     = REPLY_W'(sz_q);
          state_d   = S_WQ;
          if (cnt_q == CNT_W'(1)) begin
            first_d = '0;
            state_d = S_CLR;
          end else if (idx_q == '0) begin
            first_d      = nxt_q;
            wq_addr_d[0] = nxt_q + VW'(4); wq_data_d[0] = '0;
            wq_n_d       = 3'd1;
          end else if (is_last) begin
            wq_addr_d[0] = prv_q; wq_data_d[0] = '0;
            wq_n_d       = 3'd1;
          end else begin
            wq_addr_d[0] = prv_q;          wq_data_d[0] = 32'(nxt_q);
            wq_addr_d[1] = nxt_q + VW'(4); wq_data_d[1] = 32'(prv_q);
            wq_n_d       = 3'd2;
          end
        end else if (is_last) begin
          res_d   = '0;
          state_d = S_FIN;
        end else begin
          prv_d     = cur_q;
          cur_d     = nxt_q;
          idx_d     = idx_q + CNT_W'(1);
          rd_base_d = nxt_q + VW'(8);
          rd_sel_d  = 1'b0;
          state_d   = S_RD;
        end
      end

      // queued header writes, one byte a cycle, little-endian
      S_WQ: begin
        mem_addr  = wq_byte_addr[AW-1:0];
        mem_we    = (wq_byte_addr < ARENA_V);
        mem_wdata = wq_data_q[wq_idx_q][8*wb_q +: 8];
        wb_d      = wb_q + 2'd1;
        if (wb_q == 2'd3) begin
          wq_idx_d = wq_idx_q + 3'd1;
          if (wq_idx_q + 3'd1 == wq_n_q) begin
            state_d = (func_q == FUNC_FREE) ? S_CLR : ret_q;
          end
        end
      end

      S_RB: begin
        mem_addr = pos_q[AW-1:0];
        state_d  = S_RB2;
      end

      S_RB2: begin
        res_d   = (pos_q < ARENA_V) ? REPLY_W'(mem_rdata) : '0;
        state_d = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          reply_d     = res_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ret_q       <= S_IDLE;
      clr_q       <= '0;
      clr_end_q   <= ARENA_V;
      cfg_q       <= '0;
      first_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      func_q      <= FUNC_ALLOC;
      rk_q        <= '0;
      rd_sel_q    <= 1'b0;
      wq_n_q      <= '0;
      wq_idx_q    <= '0;
      wb_q        <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      clr_q       <= clr_d;
      clr_end_q   <= clr_end_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      func_q      <= func_d;
      rk_q        <= rk_d;
      rd_sel_q    <= rd_sel_d;
      wq_n_q      <= wq_n_d;
      wq_idx_q    <= wq_idx_d;
      wb_q        <= wb_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reply_q   <= reply_d;
    need_q    <= need_d;
    size_q    <= size_d;
    pos_q     <= pos_d;
    cur_q     <= cur_d;
    prv_q     <= prv_d;
    sz_q      <= sz_d;
    nxt_q     <= nxt_d;
    res_q     <= res_d;
    rd_base_q <= rd_base_d;
    rword_q   <= rword_d;
    wq_addr_q <= wq_addr_d;
    wq_data_q <= wq_data_d;
  end

endmodule

`default_nettype wire
